[design/rrc_pkg.sv]
// Shared types and constants of the rectangle raster canvas.
package rrc_pkg;

    localparam int MAX_DIM   = 512;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int DIM_W     = COORD_W + 1;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int FRAC_W    = 8;
    localparam int FIX_W     = 20;
    localparam int CRD_W     = 23;
    localparam int CHAR_W    = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);
    localparam logic [CRD_W-1:0] FRAC_ONE  = CRD_W'(1) << FRAC_W;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BG     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SWEEP = 2'd1,
        ST_READ  = 2'd2,
        ST_RESP  = 2'd3
    } t_state;

    typedef logic signed [CRD_W-1:0] t_crd;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [CHAR_W-1:0] bg;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               filled;
        logic               rejected;
        t_crd               x0;
        t_crd               x0p;
        t_crd               x1;
        t_crd               x1m;
        t_crd               y0;
        t_crd               y0p;
        t_crd               y1;
        t_crd               y1m;
        logic [CHAR_W-1:0]  paint;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_cmd;

    function automatic logic [DIM_W-1:0] dim_in_use(input logic [DIM_W-1:0] d);
        return (d > DIM_LIMIT) ? DIM_LIMIT : d;
    endfunction

endpackage

[design/rrc_front.sv]
// Front end: takes input transactions, checks sizes and derives edge bounds.
module rrc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rrc_pkg::OP_W-1:0]    i_opcode,
    input  logic                        i_shape_kind,
    input  logic signed [rrc_pkg::FIX_W-1:0] i_left_x,
    input  logic signed [rrc_pkg::FIX_W-1:0] i_top_y,
    input  logic signed [rrc_pkg::FIX_W-1:0] i_rect_width,
    input  logic signed [rrc_pkg::FIX_W-1:0] i_rect_height,
    input  logic [rrc_pkg::CHAR_W-1:0]  i_paint_char,
    input  logic [rrc_pkg::COORD_W-1:0] i_read_col,
    input  logic [rrc_pkg::COORD_W-1:0] i_read_row,
    output logic                        o_push,
    output rrc_pkg::t_cmd               o_cmd,
    input  logic                        i_full
);
    import rrc_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    t_crd x0, y0, x1, y1;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign o_cmd   = r_cmd;

    always_comb begin
        x0 = t_crd'(i_left_x);
        y0 = t_crd'(i_top_y);
        x1 = x0 + t_crd'(i_rect_width);
        y1 = y0 + t_crd'(i_rect_height);
        n_cmd.op       = i_opcode;
        n_cmd.filled   = i_shape_kind;
        n_cmd.rejected = (i_rect_width <= 0) || (i_rect_height <= 0);
        n_cmd.x0       = x0;
        n_cmd.x0p      = x0 + FRAC_ONE;
        n_cmd.x1       = x1;
        n_cmd.x1m      = x1 - FRAC_ONE;
        n_cmd.y0       = y0;
        n_cmd.y0p      = y0 + FRAC_ONE;
        n_cmd.y1       = y1;
        n_cmd.y1m      = y1 - FRAC_ONE;
        n_cmd.paint    = i_paint_char;
        n_cmd.col      = i_read_col;
        n_cmd.row      = i_read_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[design/rrc_cmd_fifo.sv]
// Short command queue between front end and back end.
module rrc_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rrc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rrc_pkg::t_cmd o_cmd
);
    import rrc_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full  = (r_count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/rrc_back.sv]
// Back end: pixel sweep sequencer, canvas memory and result register.
module rrc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rrc_pkg::t_cfg               i_cfg,
    input  logic                        i_cmd_valid,
    input  rrc_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_status,
    output logic [rrc_pkg::CHAR_W-1:0]  o_pixel_value
);
    import rrc_pkg::*;

    logic [CHAR_W-1:0]  r_canvas [MAX_DIM * MAX_DIM];
    logic [CHAR_W-1:0]  r_rd_data;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic               r_out_valid;
    logic               r_status;
    logic [CHAR_W-1:0]  r_pixel;

    logic [DIM_W-1:0]   w_use, h_use;
    logic               last_col, last_row, empty_canvas, in_range;
    t_crd               px, py;
    logic               cspan, rspan, near_l, near_r, near_t, near_b, hit;
    logic               wr_en, load_out;
    logic [CHAR_W-1:0]  wr_data;

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_pixel_value = r_pixel;

    always_comb begin
        w_use        = dim_in_use(i_cfg.width);
        h_use        = dim_in_use(i_cfg.height);
        empty_canvas = (w_use == '0) || (h_use == '0);
        last_col     = ({1'b0, r_col} == w_use - 1'b1);
        last_row     = ({1'b0, r_row} == h_use - 1'b1);
        in_range     = ({1'b0, r_cmd.col} < w_use) && ({1'b0, r_cmd.row} < h_use);

        px     = t_crd'({r_col, FRAC_W'(0)});
        py     = t_crd'({r_row, FRAC_W'(0)});
        cspan  = (px >= r_cmd.x0) && (px <= r_cmd.x1);
        rspan  = (py >= r_cmd.y0) && (py <= r_cmd.y1);
        near_l = (px >= r_cmd.x0) && (px < r_cmd.x0p);
        near_r = (px <= r_cmd.x1) && (px > r_cmd.x1m);
        near_t = (py >= r_cmd.y0) && (py < r_cmd.y0p);
        near_b = (py <= r_cmd.y1) && (py > r_cmd.y1m);
        if (r_cmd.filled) begin
            hit = cspan && rspan;
        end else begin
            hit = (rspan && (near_l || near_r)) || (cspan && (near_t || near_b));
        end
        wr_data = (r_cmd.op == OP_CLEAR) ? i_cfg.bg : r_cmd.paint;
    end

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_pop = 1'b1;
                    n_col = '0;
                    n_row = '0;
                    case (i_cmd.op)
                        OP_CLEAR: n_state = empty_canvas ? ST_RESP : ST_SWEEP;
                        OP_DRAW:  n_state = (empty_canvas || i_cmd.rejected) ?
                                            ST_RESP : ST_SWEEP;
                        OP_READ:  n_state = ST_READ;
                        default:  n_state = ST_RESP;
                    endcase
                end
            end
            ST_SWEEP: begin
                wr_en = (r_cmd.op == OP_CLEAR) || hit;
                if (last_col) begin
                    n_col = '0;
                    if (last_row) begin
                        n_state = ST_RESP;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_READ: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                load_out = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_row <= n_row;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (load_out) begin
            r_status <= (r_cmd.op == OP_DRAW) && r_cmd.rejected;
            r_pixel  <= ((r_cmd.op == OP_READ) && in_range) ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_canvas[{r_row, r_col}] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_canvas[{r_cmd.row, r_cmd.col}];
    end

endmodule

[design/rect_raster_canvas.sv]
// Character canvas with clear, rectangle fill/outline draw and pixel read.
//
// Input channel (i_valid/o_ready) carries one command per transaction:
// clear, draw rectangle or read pixel. Output channel (o_valid/i_ready)
// returns exactly one result per command, in order: a status bit (draw
// rejected for a size not above zero) and the pixel read.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
// index 0 canvas width, 1 canvas height, 2 background character; write only
// while no command is outstanding.
// A read passes the front register, the queue and the read and response
// states of the back end; a rejected draw, an unused opcode or a clear or
// draw on an empty canvas goes straight to the response state. A clear or
// draw sweeps every pixel in use at one pixel per cycle through the single
// canvas write port. Commands are carried out one at a time: a queued
// command starts only once the previous result has been taken.
// A four-entry queue behind the front register keeps accepting commands
// while the back end sweeps or while the receiver stalls; the finished
// result waits in the output register until taken.
// Reset restores width 256, height 256, background 32 and empties the queue.
module rect_raster_canvas (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rrc_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rrc_pkg::OP_W-1:0]         i_opcode,
    input  logic                             i_shape_kind,
    input  logic signed [rrc_pkg::FIX_W-1:0] i_left_x,
    input  logic signed [rrc_pkg::FIX_W-1:0] i_top_y,
    input  logic signed [rrc_pkg::FIX_W-1:0] i_rect_width,
    input  logic signed [rrc_pkg::FIX_W-1:0] i_rect_height,
    input  logic [rrc_pkg::CHAR_W-1:0]       i_paint_char,
    input  logic [rrc_pkg::COORD_W-1:0]      i_read_col,
    input  logic [rrc_pkg::COORD_W-1:0]      i_read_row,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_status,
    output logic [rrc_pkg::CHAR_W-1:0]       o_pixel_value
);
    import rrc_pkg::*;

    t_cfg r_cfg;
    logic push, full, pop, q_valid;
    t_cmd front_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= DIM_W'(256);
            r_cfg.height <= DIM_W'(256);
            r_cfg.bg     <= CHAR_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[DIM_W-1:0];
                CFG_BG:     r_cfg.bg     <= i_cfg_data[CHAR_W-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    rrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_shape_kind  (i_shape_kind),
        .i_left_x      (i_left_x),
        .i_top_y       (i_top_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_paint_char  (i_paint_char),
        .i_read_col    (i_read_col),
        .i_read_row    (i_read_row),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_full        (full)
    );

    rrc_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    rrc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_pixel_value (o_pixel_value)
    );

endmodule
